// ===== rtl/bch44_pkg.sv =====
package bch44_pkg;

	localparam int CW_BITS = 44;
	localparam int SYN_BITS = 12;
	localparam int POS_BITS = 8;
	localparam int ROW_MAX = 21;
	localparam int TBL_DEPTH = 1 << SYN_BITS;
	localparam int ENTRY_BITS = 2 * POS_BITS;
	localparam logic [POS_BITS-1:0] NO_POS = 8'hFF;
	localparam logic [ENTRY_BITS-1:0] ENTRY_RESET = {NO_POS, NO_POS};

	// Command codes of an input word
	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		STAT_CLEAN     = 2'd0,
		STAT_CORRECTED = 2'd1,
		STAT_UNCORR    = 2'd2
	} status_t;

	typedef struct packed {
		logic                cmd;
		logic [CW_BITS-1:0]  code_word;
		logic [SYN_BITS-1:0] entry_index;
		logic [POS_BITS-1:0] entry_first;
		logic [POS_BITS-1:0] entry_second;
	} in_word_t;

	typedef struct packed {
		logic [CW_BITS-1:0]  corrected_word;
		status_t             status;
		logic [SYN_BITS-1:0] syndrome_value;
	} out_word_t;

	typedef logic [POS_BITS-1:0] row_list_t [ROW_MAX];

	// Parity-check rows; unused slots hold NO_POS
	localparam row_list_t CHECK_ROWS [SYN_BITS] = '{
		'{8'd0, 8'd12, 8'd15, 8'd16, 8'd17, 8'd18, 8'd21, 8'd22, 8'd24, 8'd28, 8'd29,
		  8'd33, 8'd34, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd255, 8'd255},
		'{8'd1, 8'd13, 8'd16, 8'd17, 8'd18, 8'd19, 8'd22, 8'd23, 8'd25, 8'd29, 8'd30,
		  8'd34, 8'd35, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd255, 8'd255},
		'{8'd2, 8'd12, 8'd14, 8'd15, 8'd16, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd26,
		  8'd28, 8'd29, 8'd30, 8'd31, 8'd33, 8'd34, 8'd35, 8'd37, 8'd42, 8'd43},
		'{8'd3, 8'd13, 8'd15, 8'd16, 8'd17, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd27,
		  8'd29, 8'd30, 8'd31, 8'd32, 8'd34, 8'd35, 8'd36, 8'd38, 8'd43, 8'd255},
		'{8'd4, 8'd12, 8'd14, 8'd15, 8'd23, 8'd25, 8'd29, 8'd30, 8'd31, 8'd32, 8'd34,
		  8'd35, 8'd38, 8'd40, 8'd41, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd5, 8'd13, 8'd15, 8'd16, 8'd24, 8'd26, 8'd30, 8'd31, 8'd32, 8'd33, 8'd35,
		  8'd36, 8'd39, 8'd41, 8'd42, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd6, 8'd14, 8'd16, 8'd17, 8'd25, 8'd27, 8'd31, 8'd32, 8'd33, 8'd34, 8'd36,
		  8'd37, 8'd40, 8'd42, 8'd43, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd7, 8'd12, 8'd16, 8'd21, 8'd22, 8'd24, 8'd26, 8'd29, 8'd32, 8'd35, 8'd36,
		  8'd39, 8'd40, 8'd43, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd8, 8'd12, 8'd13, 8'd15, 8'd16, 8'd18, 8'd21, 8'd23, 8'd24, 8'd25, 8'd27,
		  8'd28, 8'd29, 8'd30, 8'd34, 8'd38, 8'd39, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd9, 8'd12, 8'd13, 8'd14, 8'd15, 8'd18, 8'd19, 8'd21, 8'd25, 8'd26, 8'd30,
		  8'd31, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd41, 8'd255, 8'd255},
		'{8'd10, 8'd13, 8'd14, 8'd15, 8'd16, 8'd19, 8'd20, 8'd22, 8'd26, 8'd27, 8'd31,
		  8'd32, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd42, 8'd255, 8'd255},
		'{8'd11, 8'd14, 8'd15, 8'd16, 8'd17, 8'd20, 8'd21, 8'd23, 8'd27, 8'd28, 8'd32,
		  8'd33, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd43, 8'd255, 8'd255}
	};

	// Build the bit mask of one parity-check row from its position list
	function automatic logic [CW_BITS-1:0] row_mask(input int r);
		logic [CW_BITS-1:0] m;
		m = '0;
		for (int k = 0; k < ROW_MAX; k++) begin
			if (int'(CHECK_ROWS[r][k]) < CW_BITS) begin
				m[CHECK_ROWS[r][k][5:0]] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/bch_44_32_table_decoder_top.sv =====
// A decode word passes the stage 1 register and then the output register.
// Throughput: one word per cycle unless stage 1 stalls, decode or table write;
// one correction table read per decode word from a synchronous RAM with one
// write port and one read port. Table writes give no output word.
// Reset: asynchronous, active low; afterwards a clearing pass sets all 4096
// table entries to uncorrectable, one per cycle, and in_ready stays low for it.
module bch_44_32_table_decoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bch44_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bch44_pkg::out_word_t out_data
);
	import bch44_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t               state_q;
	logic [SYN_BITS-1:0]  clr_idx_q;

	logic [ENTRY_BITS-1:0] tbl_mem [TBL_DEPTH];

	logic                 in_fire;
	logic                 dec_fire;
	logic                 s1_adv;
	logic [SYN_BITS-1:0]  syn;

	logic                 mem_we;
	logic [SYN_BITS-1:0]  mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata;

	logic                 valid_s1;
	logic [CW_BITS-1:0]   word_s1;
	logic [SYN_BITS-1:0]  syn_s1;
	logic [ENTRY_BITS-1:0] entry_s1;

	logic [POS_BITS-1:0]  first_pos;
	logic [POS_BITS-1:0]  second_pos;
	logic [CW_BITS-1:0]   flip_mask;
	out_word_t            result;

	logic                 out_valid_q;
	out_word_t            out_q;

	bch44_syndrome u_syndrome (
		.word     (in_data.code_word),
		.syndrome (syn)
	);

	// Advance stage 1 when the output register is free or being drained
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_RUN) && (!valid_s1 || s1_adv);
	assign in_fire  = in_valid && in_ready;
	assign dec_fire = in_fire && (in_data.cmd == CMD_DECODE);

	// Clear sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == SYN_BITS'(TBL_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Select the write port between clearing and table write words
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = ENTRY_RESET;
		end else begin
			mem_we    = in_fire && (in_data.cmd == CMD_WRITE);
			mem_waddr = in_data.entry_index;
			mem_wdata = {in_data.entry_first, in_data.entry_second};
		end
	end

	// Correction table RAM; read data holds while stage 1 stalls
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (dec_fire) begin
			entry_s1 <= tbl_mem[syn];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= dec_fire;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (dec_fire) begin
			word_s1 <= in_data.code_word;
			syn_s1  <= syn;
		end
	end

	// Apply the table entry to the stored word
	always_comb begin
		first_pos  = entry_s1[ENTRY_BITS-1:POS_BITS];
		second_pos = entry_s1[POS_BITS-1:0];
		flip_mask  = '0;
		result.syndrome_value = syn_s1;
		if (syn_s1 == '0) begin
			result.status = STAT_CLEAN;
		end else if (first_pos >= POS_BITS'(CW_BITS)) begin
			result.status = STAT_UNCORR;
		end else begin
			result.status = STAT_CORRECTED;
			flip_mask[first_pos[5:0]] = 1'b1;
			if (second_pos < POS_BITS'(CW_BITS)) begin
				flip_mask[second_pos[5:0]] = flip_mask[second_pos[5:0]] ^ 1'b1;
			end
		end
		result.corrected_word = word_s1 ^ flip_mask;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("word accepted during table clear");

	a_clean_zero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_CLEAN) |-> (out_q.syndrome_value == '0))
		else $error("clean status with nonzero syndrome");

	a_no_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.status == STAT_CLEAN || out_q.status == STAT_CORRECTED ||
			out_q.status == STAT_UNCORR))
		else $error("illegal status code");

	a_decode_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		dec_fire |=> valid_s1)
		else $error("decode word lost before stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(syn_s1) && $stable(entry_s1)))
		else $error("stalled stage 1 word changed");

endmodule

// ===== rtl/bch44_syndrome.sv =====
module bch44_syndrome (
	input  logic [bch44_pkg::CW_BITS-1:0]  word,
	output logic [bch44_pkg::SYN_BITS-1:0] syndrome
);
	import bch44_pkg::*;

	// Reduce each parity-check row to one syndrome bit
	for (genvar r = 0; r < SYN_BITS; r++) begin : g_row
		localparam logic [CW_BITS-1:0] Mask = row_mask(r);
		assign syndrome[r] = ^(word & Mask);
	end

endmodule
